// File: hdl/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// Shared sizes, register indexes and reset values of the permutation shuffler.
// ----------------------------------------------------------------------------
package rps_pkg;

  // Table and random word geometry
  localparam int TABLE_DEPTH = 16;
  localparam int RAND_BITS   = 31;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = IDX_W + 1;              // holds TABLE_DEPTH and n - i
  localparam int CYC_W = $clog2(RAND_BITS);      // divider bit counter
  localparam int DVS_W = RAND_BITS + IDX_W - 1;  // aligned divisor

  // Field widths
  localparam int COUNT_W    = 5;
  localparam int OFFSET_W   = 8;
  localparam int VALUE_W    = 9;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_OFFSET = 1'd1;

  // Register reset values
  localparam logic [COUNT_W-1:0]  ENTRY_COUNT_RST  = 5'd16;
  localparam logic [OFFSET_W-1:0] VALUE_OFFSET_RST = 8'd0;

  // Smallest permutation
  localparam int MIN_COUNT = 2;

endpackage

// File: hdl/random_permutation_shuffler.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// Fisher-Yates shuffle engine over a small table, one swap per random item.
// ----------------------------------------------------------------------------
// Each accepted item carries one random word r for swap step i of an
// n-entry permutation (n = entry_count clamped to 2..TABLE_DEPTH). The block
// picks j = i + r / (RMAX / (n - i) + 1) and swaps table entries i and j.
// Items stall until the current one is through: the bit-serial divider
// producing RMAX / (n - i) runs one quotient bit per cycle in DIV1, PREP
// aligns the divisor, a short restoring divider in DIV2 finds r / divisor
// with log2(TABLE_DEPTH) quotient bits since that quotient is below n, the
// swap runs through SWAP_RD_I, SWAP_RD_J, SWAP_WR_I and SWAP_WR_J on the
// single-write, single-read table RAM, and IDLE takes the next item. The
// item that finishes a permutation then emits n results in table order,
// each plus value_offset, read in EMIT_RD and loaded in EMIT_LOAD once the
// output register is free, with last_entry on the final one. Per-entry
// valid bits make the table read as 1..n after reset and after each
// permutation, so there is no clearing pass. The next item is accepted as
// soon as the last result sits in the output register. The user must write
// configuration only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module random_permutation_shuffler (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [rps_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rps_pkg::CFG_DATA_W-1:0]      cfg_data,
  // random items
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic [rps_pkg::RAND_BITS-1:0]       random_word,
  // results
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [rps_pkg::VALUE_W-1:0]         entry_value,
  output logic                                last_entry
);

  typedef enum logic [3:0] {
    IDLE,
    DIV1,
    PREP,
    DIV2,
    SWAP_RD_I,
    SWAP_RD_J,
    SWAP_WR_I,
    SWAP_WR_J,
    EMIT_RD,
    EMIT_LOAD
  } state_t;

  state_t state;

  // configuration registers
  logic [rps_pkg::COUNT_W-1:0]  entry_count;
  logic [rps_pkg::OFFSET_W-1:0] value_offset;

  // step state
  logic [rps_pkg::IDX_W-1:0]     swap_step;
  logic [rps_pkg::IDX_W-1:0]     emit_idx;
  logic [rps_pkg::IDX_W-1:0]     pick;
  logic [rps_pkg::TABLE_DEPTH-1:0] ent_vld;

  // divider state
  logic [rps_pkg::CYC_W-1:0]     bit_cnt;
  logic [rps_pkg::IDX_W-1:0]     rem1;
  logic [rps_pkg::RAND_BITS-1:0] quo1;
  logic [rps_pkg::RAND_BITS-1:0] rem2;
  logic [rps_pkg::DVS_W-1:0]     dvs;
  logic [rps_pkg::IDX_W-1:0]     quo2;

  // table access
  logic                          ram_wr_en;
  logic [rps_pkg::IDX_W-1:0]     ram_wr_addr;
  logic [rps_pkg::CNT_W-1:0]     ram_wr_data;
  logic [rps_pkg::IDX_W-1:0]     ram_rd_addr;
  logic [rps_pkg::CNT_W-1:0]     ram_rd_data;
  logic [rps_pkg::IDX_W-1:0]     rd_addr_q;
  logic                          rd_vld_q;
  logic [rps_pkg::CNT_W-1:0]     rd_val;
  logic [rps_pkg::CNT_W-1:0]     swap_tmp;

  // combinational helpers
  logic [rps_pkg::CNT_W-1:0]     n_eff;
  logic [rps_pkg::CNT_W-1:0]     span;
  logic [rps_pkg::CNT_W-1:0]     trial1;
  logic                          ge1;
  logic [rps_pkg::IDX_W-1:0]     rem1_next;
  logic                          ge2;
  logic [rps_pkg::CNT_W-1:0]     pick_sum;
  logic [rps_pkg::IDX_W-1:0]     pick_next;
  logic                          out_free;
  logic                          emit_last;
  logic                          item_acc;

  // effective count, clamped into range
  always_comb begin
    if (entry_count < rps_pkg::COUNT_W'(rps_pkg::MIN_COUNT)) begin
      n_eff = rps_pkg::CNT_W'(rps_pkg::MIN_COUNT);
    end else if (int'(entry_count) > rps_pkg::TABLE_DEPTH) begin
      n_eff = rps_pkg::CNT_W'(rps_pkg::TABLE_DEPTH);
    end else begin
      n_eff = rps_pkg::CNT_W'(entry_count);
    end
  end

  assign span = n_eff - rps_pkg::CNT_W'(swap_step);

  // RMAX / span: dividend is all ones, shift in a one each cycle
  assign trial1    = {rem1, 1'b1};
  assign ge1       = (trial1 >= span);
  assign rem1_next = ge1 ? rps_pkg::IDX_W'(trial1 - span) : rps_pkg::IDX_W'(trial1);

  // r / divisor, quotient known to stay below the table depth
  assign ge2 = (rps_pkg::DVS_W'(rem2) >= dvs);

  always_comb begin
    pick_sum = rps_pkg::CNT_W'(swap_step) + rps_pkg::CNT_W'(quo2);
    if (pick_sum > n_eff - 1'b1) begin
      pick_next = rps_pkg::IDX_W'(n_eff - 1'b1);
    end else begin
      pick_next = rps_pkg::IDX_W'(pick_sum);
    end
  end

  // never-written entries read as their reload value
  assign rd_val = rd_vld_q ? ram_rd_data : rps_pkg::CNT_W'(rd_addr_q) + 1'b1;

  assign out_free   = !result_valid || !result_stall;
  assign emit_last  = (rps_pkg::CNT_W'(emit_idx) == n_eff - 1'b1);
  assign item_stall = (state != IDLE);
  assign item_acc   = item_valid && !item_stall;

  always_comb begin
    case (state)
      SWAP_RD_I:          ram_rd_addr = swap_step;
      EMIT_RD, EMIT_LOAD: ram_rd_addr = emit_idx;
      default:            ram_rd_addr = pick;
    endcase
  end

  assign ram_wr_en   = (state == SWAP_WR_I) || (state == SWAP_WR_J);
  assign ram_wr_addr = (state == SWAP_WR_I) ? swap_step : pick;
  assign ram_wr_data = (state == SWAP_WR_I) ? rd_val : swap_tmp;

  rps_ram #(
    .WIDTH (rps_pkg::CNT_W),
    .DEPTH (rps_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    rd_addr_q <= ram_rd_addr;
    rd_vld_q  <= ent_vld[ram_rd_addr];
  end

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= rps_pkg::ENTRY_COUNT_RST;
      value_offset <= rps_pkg::VALUE_OFFSET_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        rps_pkg::REG_ENTRY_COUNT:  entry_count  <= cfg_data[rps_pkg::COUNT_W-1:0];
        rps_pkg::REG_VALUE_OFFSET: value_offset <= cfg_data[rps_pkg::OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      swap_step    <= '0;
      ent_vld      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (item_acc) begin
            rem2     <= random_word;
            emit_idx <= '0;
            if (rps_pkg::CNT_W'(swap_step) + 1'b1 < n_eff) begin
              rem1    <= '0;
              bit_cnt <= rps_pkg::CYC_W'(rps_pkg::RAND_BITS - 1);
              state   <= DIV1;
            end else begin
              // count lowered below the current step: emit at once
              state <= EMIT_RD;
            end
          end
        end
        DIV1: begin
          rem1 <= rem1_next;
          quo1 <= rps_pkg::RAND_BITS'({quo1, ge1});
          if (bit_cnt == '0) begin
            state <= PREP;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        PREP: begin
          dvs     <= (rps_pkg::DVS_W'(quo1) + 1'b1) << (rps_pkg::IDX_W - 1);
          bit_cnt <= rps_pkg::CYC_W'(rps_pkg::IDX_W - 1);
          state   <= DIV2;
        end
        DIV2: begin
          if (ge2) begin
            rem2 <= rps_pkg::RAND_BITS'(rps_pkg::DVS_W'(rem2) - dvs);
          end
          quo2 <= rps_pkg::IDX_W'({quo2, ge2});
          dvs  <= dvs >> 1;
          if (bit_cnt == '0) begin
            state <= SWAP_RD_I;
          end else begin
            bit_cnt <= bit_cnt - 1'b1;
          end
        end
        SWAP_RD_I: begin
          pick  <= pick_next;
          state <= SWAP_RD_J;
        end
        SWAP_RD_J: begin
          swap_tmp <= rd_val;
          state    <= SWAP_WR_I;
        end
        SWAP_WR_I: begin
          ent_vld[swap_step] <= 1'b1;
          state              <= SWAP_WR_J;
        end
        SWAP_WR_J: begin
          ent_vld[pick] <= 1'b1;
          if (rps_pkg::CNT_W'(swap_step) + 2'd2 < n_eff) begin
            swap_step <= swap_step + 1'b1;
            state     <= IDLE;
          end else begin
            state <= EMIT_RD;
          end
        end
        EMIT_RD: begin
          state <= EMIT_LOAD;
        end
        EMIT_LOAD: begin
          // hold the read until the output register frees up
          if (out_free) begin
            result_valid <= 1'b1;
            entry_value  <= rps_pkg::VALUE_W'(rd_val) + rps_pkg::VALUE_W'(value_offset);
            last_entry   <= emit_last;
            if (emit_last) begin
              ent_vld   <= '0;
              swap_step <= '0;
              state     <= IDLE;
            end else begin
              emit_idx <= emit_idx + 1'b1;
              state    <= EMIT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  // the running remainder of the first divider stays below its divisor
  a_rem1_range: assert property (@(posedge clk) disable iff (rst)
    (state == DIV1) |-> (rps_pkg::CNT_W'(rem1) < span))
    else $error("first divider remainder out of range");

  // the pick offset never reaches past the current span
  a_pick_range: assert property (@(posedge clk) disable iff (rst)
    (state == SWAP_RD_I) |-> (rps_pkg::CNT_W'(quo2) < span))
    else $error("swap pick beyond the table span");

  // loading the final result reloads the table
  a_reload: assert property (@(posedge clk) disable iff (rst)
    (state == EMIT_LOAD && out_free && emit_last)
      |=> (swap_step == '0 && ent_vld == '0 && state == IDLE))
    else $error("table not reloaded after the final result");

endmodule

// File: hdl/rps_ram.sv
// ----------------------------------------------------------------------------
// rps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: tb/sv/tb_random_permutation_shuffler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_random_permutation_shuffler
// Self-checking bench for the Fisher-Yates permutation shuffler.
// ----------------------------------------------------------------------------
// Random words go in one item at a time and the bench keeps its own copy of
// the table, swap step and registers, so that each finished permutation is
// predicted entry by entry and compared with what the block emits. The tests
// cover the default size, clamped and extreme counts, the offset range, a
// count cut below the current step, long output hold-offs and random idling
// on both sides with several register settings.
// ----------------------------------------------------------------------------
module tb_random_permutation_shuffler;

  localparam longint unsigned WORD_MAX    = (64'd1 << rps_pkg::RAND_BITS) - 1;
  localparam int              CYCLE_LIMIT = 400000;
  localparam int              QUIET_WAIT  = 120;

  typedef struct packed {
    logic [rps_pkg::VALUE_W-1:0] value;
    logic                        last;
  } perm_out_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_write = 1'b0;
  logic [rps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rps_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  logic [rps_pkg::RAND_BITS-1:0]  random_word = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic [rps_pkg::VALUE_W-1:0]    entry_value;
  logic                           last_entry;

  // Bench copy of the block state
  logic [rps_pkg::COUNT_W-1:0]  count_reg;
  logic [rps_pkg::OFFSET_W-1:0] offset_reg;
  logic [rps_pkg::CNT_W-1:0]    perm_model [rps_pkg::TABLE_DEPTH];
  int                           step_model;

  perm_out_t perm_expected[$];
  int        error_count = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 0;
  int        sink_stall_pct = 0;
  int        hold_left = 0;

  random_permutation_shuffler u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .random_word  (random_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .entry_value  (entry_value),
    .last_entry   (last_entry)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random stalls, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    perm_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (perm_expected.size() == 0) begin
        error_count++;
        $display("%0t: entry expected none got %0d last %0b", $time, entry_value,
                 last_entry);
      end else begin
        want = perm_expected.pop_front();
        if (entry_value !== want.value) begin
          error_count++;
          $display("%0t: entry_value expected %0d got %0d", $time, want.value, entry_value);
        end
        if (last_entry !== want.last) begin
          error_count++;
          $display("%0t: last_entry expected %0b got %0b", $time, want.last, last_entry);
        end
      end
    end
  end

  function automatic void reload_perm();
    for (int k = 0; k < rps_pkg::TABLE_DEPTH; k++) perm_model[k] = rps_pkg::CNT_W'(k + 1);
    step_model = 0;
  endfunction

  // One swap step; emit the whole permutation once the last step is done
  function automatic void shuffle_predict(logic [rps_pkg::RAND_BITS-1:0] word);
    int                       n;
    int                       i;
    longint unsigned          div_val;
    longint unsigned          pick;
    logic [rps_pkg::CNT_W-1:0] tmp;
    perm_out_t                res;
    n = (count_reg < rps_pkg::MIN_COUNT) ? rps_pkg::MIN_COUNT :
        (count_reg > rps_pkg::TABLE_DEPTH) ? rps_pkg::TABLE_DEPTH : int'(count_reg);
    i = step_model;
    if (i < n - 1) begin
      div_val = WORD_MAX / longint'(n - i) + 1;
      pick = longint'(i) + longint'(word) / div_val;
      if (pick > longint'(n - 1)) pick = longint'(n - 1);
      tmp = perm_model[pick];
      perm_model[pick] = perm_model[i];
      perm_model[i] = tmp;
      if (i + 1 < n - 1) begin
        step_model = i + 1;
        return;
      end
    end
    for (int k = 0; k < n; k++) begin
      res.value = rps_pkg::VALUE_W'(perm_model[k]) + rps_pkg::VALUE_W'(offset_reg);
      res.last  = (k == n - 1);
      perm_expected.push_back(res);
    end
    reload_perm();
  endfunction

  function automatic logic [rps_pkg::RAND_BITS-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return rps_pkg::RAND_BITS'(WORD_MAX);
      2:       return rps_pkg::RAND_BITS'(WORD_MAX - $urandom_range(0, 255));
      3:       return rps_pkg::RAND_BITS'($urandom_range(0, 255));
      default: return rps_pkg::RAND_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [rps_pkg::CFG_DATA_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return rps_pkg::CFG_DATA_W'(0);
      1:       return rps_pkg::CFG_DATA_W'(1);
      2:       return rps_pkg::CFG_DATA_W'(2);
      3:       return rps_pkg::CFG_DATA_W'(rps_pkg::TABLE_DEPTH);
      4:       return rps_pkg::CFG_DATA_W'(31);
      5:       return rps_pkg::CFG_DATA_W'($urandom_range(rps_pkg::TABLE_DEPTH + 1, 31));
      default: return rps_pkg::CFG_DATA_W'($urandom_range(2, 6));
    endcase
  endfunction

  task automatic send_word(logic [rps_pkg::RAND_BITS-1:0] word);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid  <= 1'b1;
    random_word <= word;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    shuffle_predict(word);
  endtask

  task automatic drain();
    while (perm_expected.size() != 0) @(posedge clk);
  endtask

  // Drop valid, let every result out and give a busy step time to finish
  task automatic settle();
    @(negedge clk);
    item_valid <= 1'b0;
    drain();
    repeat (QUIET_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [rps_pkg::CFG_IDX_W-1:0] idx,
                           logic [rps_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == rps_pkg::REG_ENTRY_COUNT) count_reg = data[rps_pkg::COUNT_W-1:0];
    else offset_reg = data[rps_pkg::OFFSET_W-1:0];
  endtask

  task automatic test_default_count();
    send_word('0);
    send_word(rps_pkg::RAND_BITS'(WORD_MAX));
    send_word(31'h5555_5555);
    send_word(31'h2AAA_AAAA);
    repeat (11) send_word(rps_pkg::RAND_BITS'($urandom));
    settle();
  endtask

  // Counts below two act as two; offset 255 still fits the nine-bit value
  task automatic test_count_limits();
    write_reg(rps_pkg::REG_VALUE_OFFSET, 8'd255);
    write_reg(rps_pkg::REG_ENTRY_COUNT, 8'd0);
    send_word(rps_pkg::RAND_BITS'(WORD_MAX));
    settle();
    write_reg(rps_pkg::REG_ENTRY_COUNT, 8'd1);
    send_word('0);
    settle();
    write_reg(rps_pkg::REG_ENTRY_COUNT, 8'd2);
    write_reg(rps_pkg::REG_VALUE_OFFSET, 8'd0);
    send_word(rps_pkg::RAND_BITS'(1) << (rps_pkg::RAND_BITS - 1));
    settle();
  endtask

  // Cut the count below the current step: the next item flushes at once
  task automatic test_count_cut();
    write_reg(rps_pkg::REG_ENTRY_COUNT, 8'd5);
    write_reg(rps_pkg::REG_VALUE_OFFSET, 8'd17);
    repeat (3) send_word(pick_word());
    settle();
    write_reg(rps_pkg::REG_ENTRY_COUNT, 8'd3);
    send_word(pick_word());
    settle();
  endtask

  task automatic run_phase(int src_pct, int sink_pct, int num_items);
    settle();
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    write_reg(rps_pkg::REG_ENTRY_COUNT, pick_count());
    write_reg(rps_pkg::REG_VALUE_OFFSET, 8'($urandom));
    for (int n = 0; n < num_items; n++) begin
      // Occasionally change the setup, often in the middle of a permutation
      if ($urandom_range(0, 39) == 0) begin
        settle();
        if ($urandom_range(0, 1)) write_reg(rps_pkg::REG_ENTRY_COUNT, pick_count());
        else write_reg(rps_pkg::REG_VALUE_OFFSET,
                       ($urandom_range(0, 3) == 0) ? 8'd255 : 8'($urandom));
      end
      send_word(pick_word());
    end
  endtask

  // Hold the output long enough that the block stalls its input
  task automatic test_backpressure();
    settle();
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    write_reg(rps_pkg::REG_ENTRY_COUNT, 8'd2);
    write_reg(rps_pkg::REG_VALUE_OFFSET, 8'd200);
    @(posedge clk);
    hold_left = 600;
    repeat (40) send_word(pick_word());
  endtask

  // Stop sending mid-permutation until every result is out, then go on
  task automatic test_sender_pause();
    settle();
    src_idle_pct   = 0;
    sink_stall_pct = 15;
    write_reg(rps_pkg::REG_ENTRY_COUNT, 8'd4);
    write_reg(rps_pkg::REG_VALUE_OFFSET, 8'd3);
    repeat (5) send_word(pick_word());
    @(negedge clk);
    item_valid <= 1'b0;
    drain();
    repeat (20) send_word(pick_word());
  endtask

  initial begin
    count_reg  = rps_pkg::ENTRY_COUNT_RST;
    offset_reg = rps_pkg::VALUE_OFFSET_RST;
    reload_perm();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_default_count();
    test_count_limits();
    test_count_cut();
    run_phase(0, 0, 80);
    run_phase(64, 0, 80);
    run_phase(0, 64, 80);
    run_phase(15, 15, 80);
    test_backpressure();
    test_sender_pause();

    @(negedge clk);
    item_valid <= 1'b0;
    drain();
    repeat (QUIET_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: random_permutation_shuffler.f
hdl/rps_pkg.sv
hdl/rps_ram.sv
hdl/random_permutation_shuffler.sv
tb/sv/tb_random_permutation_shuffler.sv
